// File: design/ansi_sgr_escape_filter_unit_assert.svh
// Assertion macros shared by the escape filter modules.
`ifndef ANSI_SGR_ESCAPE_FILTER_UNIT_ASSERT_SVH
`define ANSI_SGR_ESCAPE_FILTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASEF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("asef assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASEF_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("asef assertion failed");

`endif

// File: design/asef_pkg.sv
// Types, constants and the SGR code decoder shared by the escape filter modules.
package asef_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic [0:0] REG_PLAIN_ATTRIBUTE = 1'b0;
   localparam logic [15:0] PLAIN_RESET = 16'h0007;

   localparam logic [7:0] CHAR_ESC = 8'h1B;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_FINAL_SGR = 8'h6D;
   localparam logic [7:0] CHAR_FINAL_ERASE = 8'h4B;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [7:0] SGR_RESET = 8'd0;
   localparam logic [7:0] SGR_BOLD = 8'd1;
   localparam logic [7:0] SGR_FAINT = 8'd2;
   localparam logic [7:0] SGR_BLINK_SLOW = 8'd5;
   localparam logic [7:0] SGR_BLINK_FAST = 8'd6;
   localparam logic [7:0] SGR_REVERSE = 8'd7;
   localparam logic [7:0] SGR_NORMAL = 8'd22;
   localparam logic [7:0] SGR_BLINK_OFF = 8'd25;
   localparam logic [7:0] SGR_REVERSE_OFF = 8'd27;
   localparam logic [7:0] SGR_FG_FIRST = 8'd30;
   localparam logic [7:0] SGR_FG_WHITE = 8'd37;
   localparam logic [7:0] SGR_FG_DEFAULT = 8'd39;
   localparam logic [7:0] SGR_BG_FIRST = 8'd40;
   localparam logic [7:0] SGR_BG_WHITE = 8'd47;
   localparam logic [7:0] SGR_BG_DEFAULT = 8'd49;

   localparam logic [7:0] PARAM_MAX = 8'd255;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_ESC  = 2'd1,
      PHASE_CSI  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_TEXT  = 2'd0,
      KIND_ATTR  = 2'd1,
      KIND_ERASE = 2'd2
   } kind_type;

   typedef struct packed {
      logic [15:0] attribute;
      logic        reverse;
   } sgr_work_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  text_byte;
      logic [15:0] attribute;
      logic        reverse;
      logic        second;
      logic [7:0]  second_byte;
   } entry_type;

   function automatic sgr_work_type apply_code(input logic [7:0] code,
                                               input sgr_work_type work,
                                               input logic [15:0] plain);
      sgr_work_type res;
      logic [2:0]   c;
      res = work;
      c = 3'b000;
      if (code inside {[SGR_FG_FIRST:SGR_FG_WHITE]}) begin
         c = 3'(code - SGR_FG_FIRST);
         if (code != SGR_FG_WHITE) begin
            res.attribute[2:0] = 3'b000;
         end
         res.attribute[2:0] = res.attribute[2:0] | {c[0], c[1], c[2]};
      end else if (code inside {[SGR_BG_FIRST:SGR_BG_WHITE]}) begin
         c = 3'(code - SGR_BG_FIRST);
         if (code != SGR_BG_WHITE) begin
            res.attribute[6:4] = 3'b000;
         end
         res.attribute[6:4] = res.attribute[6:4] | {c[0], c[1], c[2]};
      end else begin
         case (code)
            SGR_RESET: begin
               res.attribute = plain;
               res.reverse = 1'b0;
            end
            SGR_BOLD: res.attribute[3] = 1'b1;
            SGR_FAINT, SGR_NORMAL: res.attribute[3] = 1'b0;
            SGR_BLINK_SLOW, SGR_BLINK_FAST: res.attribute[7] = 1'b1;
            SGR_BLINK_OFF: res.attribute[7] = 1'b0;
            SGR_REVERSE: res.reverse = 1'b1;
            SGR_REVERSE_OFF: res.reverse = 1'b0;
            SGR_FG_DEFAULT: res.attribute[2:0] = plain[2:0];
            SGR_BG_DEFAULT: res.attribute[6:4] = plain[6:4];
            default: res = work;
         endcase
      end
      return res;
   endfunction

endpackage

// File: design/asef_front.sv
// Parser front end: accepts stream bytes, tracks the escape state and queues commands.
module asef_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_end_of_string,
   input  logic [15:0]         plain_attribute,
   input  logic                queue_full,
   output logic                push,
   output asef_pkg::entry_type push_entry
);

   asef_pkg::phase_type    phase_ff, phase_in;
   logic [7:0]             acc_ff, acc_in;
   asef_pkg::sgr_work_type work_ff, work_in;
   asef_pkg::sgr_work_type cur_ff, cur_in;
   asef_pkg::sgr_work_type applied;
   logic                   accept;
   logic                   is_digit;
   logic                   esc_held;
   logic [11:0]            acc_sum;

   assign req_stall = queue_full;
   assign accept = req_valid & ~queue_full;
   assign is_digit = req_in_byte inside {[asef_pkg::CHAR_ZERO:asef_pkg::CHAR_NINE]};
   assign esc_held = (req_in_byte == asef_pkg::CHAR_ESC) & ~req_end_of_string;
   assign acc_sum = 12'(acc_ff) * 12'd10 + 12'(req_in_byte - asef_pkg::CHAR_ZERO);
   assign applied = asef_pkg::apply_code(acc_ff, work_ff, plain_attribute);

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            asef_pkg::PHASE_CSI: begin
               if ((is_digit || req_in_byte == asef_pkg::CHAR_SEMICOLON) &&
                   !req_end_of_string) begin
                  phase_in = asef_pkg::PHASE_CSI;
               end else begin
                  phase_in = asef_pkg::PHASE_IDLE;
               end
            end
            asef_pkg::PHASE_ESC: begin
               if (req_in_byte == asef_pkg::CHAR_LBRACKET) begin
                  phase_in = req_end_of_string ? asef_pkg::PHASE_IDLE : asef_pkg::PHASE_CSI;
               end else if (esc_held) begin
                  phase_in = asef_pkg::PHASE_ESC;
               end else begin
                  phase_in = asef_pkg::PHASE_IDLE;
               end
            end
            default: begin
               phase_in = esc_held ? asef_pkg::PHASE_ESC : asef_pkg::PHASE_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      acc_in = acc_ff;
      work_in = work_ff;
      cur_in = cur_ff;
      push = 1'b0;
      push_entry = '0;
      push_entry.kind = asef_pkg::KIND_TEXT;
      if (accept) begin
         case (phase_ff)
            asef_pkg::PHASE_CSI: begin
               if (is_digit) begin
                  acc_in = (acc_sum > 12'(asef_pkg::PARAM_MAX)) ? asef_pkg::PARAM_MAX
                                                                 : acc_sum[7:0];
               end else if (req_in_byte == asef_pkg::CHAR_SEMICOLON) begin
                  work_in = applied;
                  acc_in = '0;
               end else if (req_in_byte == asef_pkg::CHAR_FINAL_SGR) begin
                  work_in = applied;
                  cur_in = applied;
                  acc_in = '0;
                  push = 1'b1;
                  push_entry.kind = asef_pkg::KIND_ATTR;
                  push_entry.attribute = applied.attribute;
                  push_entry.reverse = applied.reverse;
               end else if (req_in_byte == asef_pkg::CHAR_FINAL_ERASE) begin
                  acc_in = '0;
                  push = 1'b1;
                  push_entry.kind = asef_pkg::KIND_ERASE;
               end else begin
                  acc_in = '0;
               end
            end
            asef_pkg::PHASE_ESC: begin
               if (req_in_byte == asef_pkg::CHAR_LBRACKET) begin
                  if (!req_end_of_string) begin
                     acc_in = '0;
                     work_in = cur_ff;
                  end
               end else begin
                  push = 1'b1;
                  push_entry.text_byte = asef_pkg::CHAR_ESC;
                  if (!esc_held) begin
                     push_entry.second = 1'b1;
                     push_entry.second_byte = req_in_byte;
                  end
               end
            end
            default: begin
               if (!esc_held) begin
                  push = 1'b1;
                  push_entry.text_byte = req_in_byte;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= asef_pkg::PHASE_IDLE;
         acc_ff <= '0;
         work_ff <= '{attribute: asef_pkg::PLAIN_RESET, reverse: 1'b0};
         cur_ff <= '{attribute: asef_pkg::PLAIN_RESET, reverse: 1'b0};
      end else begin
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         work_ff <= work_in;
         cur_ff <= cur_in;
      end
   end

endmodule

// File: design/asef_queue.sv
// Small command queue between the parser and the output stage.
`include "ansi_sgr_escape_filter_unit_assert.svh"

module asef_queue #(
   parameter int unsigned Depth = asef_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  asef_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output asef_pkg::entry_type head_entry
);

   localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   asef_pkg::entry_type   store_ff [Depth];
   logic [AddrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AddrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full = (count_ff == CountWidth'(Depth));
   assign not_empty = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AddrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `ASEF_ASSERT_IMP(a_count_bounded, 1'b1, count_ff <= CountWidth'(Depth))
   `ASEF_ASSERT_NXT(a_count_grows, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `ASEF_ASSERT_NXT(a_count_shrinks, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

// File: design/asef_back.sv
// Output stage: drains queued commands and presents one result per transfer.
`include "ansi_sgr_escape_filter_unit_assert.svh"

module asef_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  asef_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_out_byte,
   output logic [15:0]         rsp_out_attribute,
   output logic                rsp_last_result
);

   logic               rsp_valid_ff, rsp_valid_in;
   asef_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic [15:0]        rsp_attr_ff, rsp_attr_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               pend_ff, pend_in;
   logic [7:0]         pend_byte_ff, pend_byte_in;
   logic               out_free;
   logic [15:0]        shown;
   logic [15:0]        head_attr;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign pop = out_free & ~pend_ff & not_empty;
   assign head_attr = head_entry.attribute;
   assign shown = head_entry.reverse
                  ? {head_attr[15:8], head_attr[7], head_attr[2:0], head_attr[3], head_attr[6:4]}
                  : head_attr;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_attr_in = rsp_attr_ff;
      rsp_last_in = rsp_last_ff;
      pend_in = pend_ff;
      pend_byte_in = pend_byte_ff;
      if (out_free) begin
         if (pend_ff) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in = asef_pkg::KIND_TEXT;
            rsp_byte_in = pend_byte_ff;
            rsp_attr_in = '0;
            rsp_last_in = 1'b1;
            pend_in = 1'b0;
         end else if (not_empty) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in = head_entry.kind;
            rsp_byte_in = head_entry.text_byte;
            rsp_attr_in = shown;
            rsp_last_in = ~head_entry.second;
            pend_in = head_entry.second;
            pend_byte_in = head_entry.second_byte;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_last_ff <= rsp_last_in;
      pend_byte_ff <= pend_byte_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_attribute = rsp_attr_ff;
   assign rsp_last_result = rsp_last_ff;

   `ASEF_ASSERT_IMP(a_pend_matches_first, 1'b1, pend_ff == (rsp_valid_ff && !rsp_last_ff))
   `ASEF_ASSERT_IMP(a_pop_needs_entry, pop, not_empty)
   `ASEF_ASSERT_IMP(a_command_is_last, rsp_valid_ff && rsp_kind_ff != asef_pkg::KIND_TEXT,
                    rsp_last_ff)

endmodule

// File: design/ansi_sgr_escape_filter_unit.sv
// Top level of the ANSI SGR escape filter: register port, parser, queue and output stage.
//
// Input channel (req_): one stream byte per transfer, with an end-of-string mark.
// Text bytes pass through; ESC '[' sequences are parsed and become set-attribute
// or erase-line commands on the result channel (rsp_), or are dropped.
// Each input byte yields zero, one or two results; rsp_last_result marks the last.
// A byte is accepted in any cycle in which the command queue has room, so the
// sustained rate is one byte per cycle. A lone ESC released by a byte other than
// '[' that is not a further ESC without end-of-string gives two results and
// occupies the output register for two transfers. Each result is written into
// the command queue and then into the output register before it is presented.
// The parser step (a small decode and a multiply-by-ten) is combinational; the
// queue of QueueDepth entries lets the parser run on while the receiver stalls.
// When rsp_stall is high while rsp_valid is set, the output register holds; once
// the queue is full, req_stall rises until an entry drains.
// Reset empties the queue and output, returns the parser to idle and sets the
// plain attribute, working and committed attributes to 7 with reverse off.
// The plain attribute register lies at byte address 0 of the APB-style port.
module ansi_sgr_escape_filter_unit #(
   parameter int unsigned QueueDepth = asef_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_in_byte,
   input  logic                                req_end_of_string,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_kind,
   output logic [7:0]                          rsp_out_byte,
   output logic [15:0]                         rsp_out_attribute,
   output logic                                rsp_last_result,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [asef_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [asef_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [asef_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);

   logic [15:0]         plain_ff, plain_in;
   logic                reg_hit;
   logic                csr_write;
   logic                push;
   logic                pop;
   logic                queue_full;
   logic                not_empty;
   asef_pkg::entry_type push_entry;
   asef_pkg::entry_type head_entry;

   assign pready = 1'b1;
   assign reg_hit = (paddr[2] == asef_pkg::REG_PLAIN_ATTRIBUTE);
   assign csr_write = psel & penable & pwrite & pready;
   assign plain_in = (csr_write && reg_hit) ? pwdata[15:0] : plain_ff;
   assign prdata = reg_hit ? {(asef_pkg::CSR_DATA_WIDTH - 16)'(0), plain_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         plain_ff <= asef_pkg::PLAIN_RESET;
      end else begin
         plain_ff <= plain_in;
      end
   end

   asef_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .plain_attribute   (plain_ff),
      .queue_full        (queue_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   asef_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (not_empty),
      .head_entry (head_entry)
   );

   asef_back u_back (
      .clock             (clock),
      .reset             (reset),
      .not_empty         (not_empty),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_attribute (rsp_out_attribute),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

// File: tb/sv/sgr_filter_checker.sv
// Checker for the escape filter: predicts the console commands of every byte and compares them.
`timescale 1ns / 100ps

module sgr_filter_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [7:0]                          req_in_byte,
   input  logic                                req_end_of_string,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [1:0]                          rsp_kind,
   input  logic [7:0]                          rsp_out_byte,
   input  logic [15:0]                         rsp_out_attribute,
   input  logic                                rsp_last_result,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [asef_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [asef_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   input  logic [asef_pkg::CSR_DATA_WIDTH-1:0] prdata,
   input  logic                                pready,
   output int                                  mismatches,
   output int                                  outstanding
);

   localparam logic [asef_pkg::CSR_ADDR_WIDTH-1:0] PLAIN_ADDR =
      (asef_pkg::CSR_ADDR_WIDTH)'(4 * asef_pkg::REG_PLAIN_ATTRIBUTE);

   typedef struct {
      asef_pkg::kind_type kind;
      logic [7:0]         text;
      logic [15:0]        attr;
      logic               last;
   } console_cmd_type;

   console_cmd_type     console_cmds[$];
   asef_pkg::phase_type phase;
   logic [7:0]          param;
   logic [15:0]         plain;
   logic [15:0]         work_attr;
   logic [15:0]         cur_attr;
   logic                work_rev;
   logic                cur_rev;
   int                  fail_total = 0;
   int                  queued = 0;

   assign mismatches = fail_total;
   assign outstanding = queued;

   function automatic console_cmd_type make_cmd(input asef_pkg::kind_type kind,
                                                input logic [7:0] text,
                                                input logic [15:0] attr);
      console_cmd_type c;
      c.kind = kind;
      c.text = text;
      c.attr = attr;
      c.last = 1'b0;
      return c;
   endfunction

   // Colour index bit 0 is red, bit 1 green and bit 2 blue in the console encoding.
   function automatic logic [2:0] colour_bits(input logic [7:0] index);
      logic [2:0] bits;
      bits = 3'b000;
      if (index[0]) bits[2] = 1'b1;
      if (index[1]) bits[1] = 1'b1;
      if (index[2]) bits[0] = 1'b1;
      return bits;
   endfunction

   function automatic logic [15:0] shown_attr();
      if (!cur_rev) return cur_attr;
      return {cur_attr[15:7], cur_attr[2:0], cur_attr[3], cur_attr[6:4]};
   endfunction

   task automatic apply_sgr(input logic [7:0] code);
      if (code inside {[asef_pkg::SGR_FG_FIRST:asef_pkg::SGR_FG_WHITE]}) begin
         if (code != asef_pkg::SGR_FG_WHITE) work_attr[2:0] = 3'b000;
         work_attr[2:0] = work_attr[2:0] | colour_bits(code - asef_pkg::SGR_FG_FIRST);
      end else if (code inside {[asef_pkg::SGR_BG_FIRST:asef_pkg::SGR_BG_WHITE]}) begin
         if (code != asef_pkg::SGR_BG_WHITE) work_attr[6:4] = 3'b000;
         work_attr[6:4] = work_attr[6:4] | colour_bits(code - asef_pkg::SGR_BG_FIRST);
      end else begin
         case (code)
            asef_pkg::SGR_RESET: begin
               work_attr = plain;
               work_rev = 1'b0;
            end
            asef_pkg::SGR_BOLD: work_attr[3] = 1'b1;
            asef_pkg::SGR_FAINT, asef_pkg::SGR_NORMAL: work_attr[3] = 1'b0;
            asef_pkg::SGR_BLINK_SLOW, asef_pkg::SGR_BLINK_FAST: work_attr[7] = 1'b1;
            asef_pkg::SGR_BLINK_OFF: work_attr[7] = 1'b0;
            asef_pkg::SGR_REVERSE: work_rev = 1'b1;
            asef_pkg::SGR_REVERSE_OFF: work_rev = 1'b0;
            asef_pkg::SGR_FG_DEFAULT: work_attr[2:0] = plain[2:0];
            asef_pkg::SGR_BG_DEFAULT: work_attr[6:4] = plain[6:4];
            default: ;
         endcase
      end
   endtask

   task automatic filter_byte(input logic [7:0] b, input logic eos);
      console_cmd_type made[$];
      int unsigned     scaled;
      case (phase)
         asef_pkg::PHASE_CSI: begin
            phase = asef_pkg::PHASE_IDLE;
            if (b inside {[asef_pkg::CHAR_ZERO:asef_pkg::CHAR_NINE]}) begin
               scaled = param * 10 + (b - asef_pkg::CHAR_ZERO);
               param = (scaled > asef_pkg::PARAM_MAX) ? asef_pkg::PARAM_MAX : scaled[7:0];
               if (!eos) phase = asef_pkg::PHASE_CSI;
            end else if (b == asef_pkg::CHAR_SEMICOLON) begin
               apply_sgr(param);
               param = 8'd0;
               if (!eos) phase = asef_pkg::PHASE_CSI;
            end else if (b == asef_pkg::CHAR_FINAL_SGR) begin
               apply_sgr(param);
               param = 8'd0;
               cur_attr = work_attr;
               cur_rev = work_rev;
               made.push_back(make_cmd(asef_pkg::KIND_ATTR, 8'd0, shown_attr()));
            end else if (b == asef_pkg::CHAR_FINAL_ERASE) begin
               param = 8'd0;
               made.push_back(make_cmd(asef_pkg::KIND_ERASE, 8'd0, 16'd0));
            end else begin
               param = 8'd0;
            end
         end
         asef_pkg::PHASE_ESC: begin
            phase = asef_pkg::PHASE_IDLE;
            if (b == asef_pkg::CHAR_LBRACKET) begin
               if (!eos) begin
                  phase = asef_pkg::PHASE_CSI;
                  param = 8'd0;
                  work_attr = cur_attr;
                  work_rev = cur_rev;
               end
            end else begin
               made.push_back(make_cmd(asef_pkg::KIND_TEXT, asef_pkg::CHAR_ESC, 16'd0));
               if (b == asef_pkg::CHAR_ESC && !eos) phase = asef_pkg::PHASE_ESC;
               else made.push_back(make_cmd(asef_pkg::KIND_TEXT, b, 16'd0));
            end
         end
         default: begin
            phase = asef_pkg::PHASE_IDLE;
            if (b == asef_pkg::CHAR_ESC && !eos) phase = asef_pkg::PHASE_ESC;
            else made.push_back(make_cmd(asef_pkg::KIND_TEXT, b, 16'd0));
         end
      endcase
      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
      foreach (made[i]) console_cmds.push_back(made[i]);
   endtask

   function automatic void flag(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      $display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
      fail_total++;
   endfunction

   always @(posedge clock) begin : watch
      console_cmd_type want;
      if (reset) begin
         phase = asef_pkg::PHASE_IDLE;
         param = 8'd0;
         plain = asef_pkg::PLAIN_RESET;
         work_attr = asef_pkg::PLAIN_RESET;
         cur_attr = asef_pkg::PLAIN_RESET;
         work_rev = 1'b0;
         cur_rev = 1'b0;
         console_cmds.delete();
      end else begin
         if (psel && penable && pready && paddr == PLAIN_ADDR) begin
            if (pwrite) plain = pwdata[15:0];
            else if (prdata !== (asef_pkg::CSR_DATA_WIDTH)'(plain))
               flag("plain attribute read", (asef_pkg::CSR_DATA_WIDTH)'(plain), prdata);
         end
         if (req_valid && !req_stall) filter_byte(req_in_byte, req_end_of_string);
         if (rsp_valid && !rsp_stall) begin
            if (console_cmds.size() == 0) begin
               $display("%0t: transfer with no result expected, kind %0d byte %h attribute %h",
                        $time, rsp_kind, rsp_out_byte, rsp_out_attribute);
               fail_total++;
            end else begin
               want = console_cmds.pop_front();
               if (rsp_kind !== want.kind) flag("kind", 32'(want.kind), 32'(rsp_kind));
               if (rsp_out_byte !== want.text)
                  flag("out_byte", 32'(want.text), 32'(rsp_out_byte));
               if (rsp_out_attribute !== want.attr)
                  flag("out_attribute", 32'(want.attr), 32'(rsp_out_attribute));
               if (rsp_last_result !== want.last)
                  flag("last_result", 32'(want.last), 32'(rsp_last_result));
            end
         end
      end
      queued = console_cmds.size();
   end

endmodule

// File: tb/sv/testbench.sv
// Top of the escape filter testbench: clock, reset, byte and register stimulus, and the verdict.
`timescale 1ns / 100ps

module testbench;

   localparam logic [asef_pkg::CSR_ADDR_WIDTH-1:0] PLAIN_ADDR =
      (asef_pkg::CSR_ADDR_WIDTH)'(4 * asef_pkg::REG_PLAIN_ATTRIBUTE);
   localparam int unsigned BYTES_WANTED = 1450;
   localparam int unsigned PHASES = 5;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [7:0]                          req_in_byte = 8'd0;
   logic                                req_end_of_string = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [1:0]                          rsp_kind;
   logic [7:0]                          rsp_out_byte;
   logic [15:0]                         rsp_out_attribute;
   logic                                rsp_last_result;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [asef_pkg::CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [asef_pkg::CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [asef_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                                pready;
   int                                  mismatches;
   int                                  outstanding;
   int unsigned                         bytes_sent = 0;
   bit                                  no_gaps = 1'b0;
   bit                                  long_hold = 1'b0;

   ansi_sgr_escape_filter_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_in_byte(req_in_byte),
      .req_end_of_string(req_end_of_string),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_out_byte(rsp_out_byte), .rsp_out_attribute(rsp_out_attribute),
      .rsp_last_result(rsp_last_result),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   sgr_filter_checker sgr_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_in_byte(req_in_byte),
      .req_end_of_string(req_end_of_string),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_out_byte(rsp_out_byte), .rsp_out_attribute(rsp_out_attribute),
      .rsp_last_result(rsp_last_result),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL ansi_sgr_escape_filter_unit");
      $finish;
   end

   // The receiver mixes short stalls, quiet stretches and, on request, one long hold-off.
   initial begin : receiver
      int span;
      int r;
      bit hold;
      span = 0;
      hold = 1'b0;
      forever begin
         @(negedge clock);
         if (span > 0) begin
            span--;
         end else if (long_hold) begin
            long_hold = 1'b0;
            hold = 1'b1;
            span = 150;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               hold = 1'b0;
               span = $urandom_range(40, 120);
            end else if (r < 40) begin
               hold = 1'b1;
               span = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end else begin
               hold = 1'b0;
               span = $urandom_range(0, 4);
            end
         end
         rsp_stall <= hold;
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input logic [7:0] b, input logic eos);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_string <= eos;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_number(input int unsigned value);
      logic [7:0]  digits[$];
      int unsigned v;
      v = value;
      do begin
         digits.push_front(asef_pkg::CHAR_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      if ($urandom_range(0, 9) == 0) digits.push_front(asef_pkg::CHAR_ZERO);
      foreach (digits[i]) send_item(digits[i], 1'b0);
   endtask

   function automatic int unsigned pick_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return asef_pkg::SGR_FG_FIRST + $urandom_range(0, 7);
      if (r < 50) return asef_pkg::SGR_BG_FIRST + $urandom_range(0, 7);
      if (r < 80) begin
         case ($urandom_range(0, 11))
            0: return asef_pkg::SGR_RESET;
            1: return asef_pkg::SGR_BOLD;
            2: return asef_pkg::SGR_FAINT;
            3: return asef_pkg::SGR_BLINK_SLOW;
            4: return asef_pkg::SGR_BLINK_FAST;
            5: return asef_pkg::SGR_REVERSE;
            6: return asef_pkg::SGR_NORMAL;
            7: return asef_pkg::SGR_BLINK_OFF;
            8: return asef_pkg::SGR_REVERSE_OFF;
            9: return asef_pkg::SGR_FG_DEFAULT;
            10: return asef_pkg::SGR_BG_DEFAULT;
            default: return asef_pkg::SGR_REVERSE;
         endcase
      end
      if (r < 95) return $urandom_range(0, 255);
      return $urandom_range(256, 999);
   endfunction

   task automatic send_sgr();
      int count;
      count = $urandom_range(0, 4);
      send_item(asef_pkg::CHAR_ESC, 1'b0);
      send_item(asef_pkg::CHAR_LBRACKET, 1'b0);
      for (int i = 0; i < count; i++) begin
         if (i > 0) send_item(asef_pkg::CHAR_SEMICOLON, 1'b0);
         if ($urandom_range(0, 9) != 0) send_number(pick_code());
      end
      if ($urandom_range(0, 7) == 0) send_item(asef_pkg::CHAR_SEMICOLON, 1'b0);
      send_item(asef_pkg::CHAR_FINAL_SGR, $urandom_range(0, 9) == 0);
   endtask

   task automatic send_erase();
      send_item(asef_pkg::CHAR_ESC, 1'b0);
      send_item(asef_pkg::CHAR_LBRACKET, 1'b0);
      if ($urandom_range(0, 2) == 0) send_number($urandom_range(0, 2));
      send_item(asef_pkg::CHAR_FINAL_ERASE, $urandom_range(0, 5) == 0);
   endtask

   task automatic send_text();
      int count;
      logic [7:0] b;
      count = $urandom_range(1, 6);
      for (int i = 0; i < count; i++) begin
         b = ($urandom_range(0, 19) == 0) ? asef_pkg::CHAR_ESC : 8'($urandom_range(0, 255));
         send_item(b, $urandom_range(0, 9) == 0);
      end
   endtask

   task automatic send_broken();
      case ($urandom_range(0, 4))
         0: begin
            send_item(asef_pkg::CHAR_ESC, 1'b0);
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
         1: begin
            send_item(asef_pkg::CHAR_ESC, 1'b0);
            send_item(asef_pkg::CHAR_ESC, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0);
         end
         2: send_item(asef_pkg::CHAR_ESC, 1'b1);
         3: begin
            send_item(asef_pkg::CHAR_ESC, 1'b0);
            send_item(asef_pkg::CHAR_LBRACKET, 1'b0);
            send_number(pick_code());
            send_item(8'($urandom_range(0, 255)), 1'b0);
         end
         default: begin
            send_item(asef_pkg::CHAR_ESC, 1'b0);
            send_item(asef_pkg::CHAR_LBRACKET, $urandom_range(0, 1) == 0);
            send_item(asef_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b1);
         end
      endcase
   endtask

   task automatic apb_access(input logic write,
                             input logic [asef_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= PLAIN_ADDR;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // The register is only written once the stream is drained and the pipeline has settled.
   task automatic set_plain(input logic [15:0] value);
      release_req();
      wait (outstanding == 0);
      repeat (8) @(negedge clock);
      apb_access(1'b1, {16'($urandom_range(0, 65535)), value});
      apb_access(1'b0, '0);
   endtask

   initial begin : stimulus
      logic [15:0] plain_value;
      int r;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_plain(asef_pkg::PLAIN_RESET);

      // Directed bytes: extremes, a full SGR, a dropped sequence, lone escapes, erase, string ends.
      send_item(8'h41, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b0);
      send_item(asef_pkg::CHAR_ESC, 1'b0);
      send_item(asef_pkg::CHAR_LBRACKET, 1'b0);
      send_number(asef_pkg::SGR_REVERSE);
      send_item(asef_pkg::CHAR_SEMICOLON, 1'b0);
      send_number(asef_pkg::SGR_BG_FIRST + 2);
      send_item(asef_pkg::CHAR_SEMICOLON, 1'b0);
      send_item(asef_pkg::CHAR_FINAL_SGR, 1'b0);
      send_item(asef_pkg::CHAR_ESC, 1'b0);
      send_item(asef_pkg::CHAR_LBRACKET, 1'b0);
      send_number(999);
      send_item(8'h78, 1'b0);
      send_item(asef_pkg::CHAR_ESC, 1'b0);
      send_item(8'h71, 1'b0);
      send_item(asef_pkg::CHAR_ESC, 1'b0);
      send_item(asef_pkg::CHAR_ESC, 1'b0);
      send_item(8'h62, 1'b0);
      send_item(asef_pkg::CHAR_ESC, 1'b1);
      send_item(asef_pkg::CHAR_ESC, 1'b0);
      send_item(asef_pkg::CHAR_LBRACKET, 1'b0);
      send_item(asef_pkg::CHAR_FINAL_ERASE, 1'b0);
      send_item(asef_pkg::CHAR_ESC, 1'b0);
      send_item(asef_pkg::CHAR_LBRACKET, 1'b0);
      send_item(asef_pkg::CHAR_ZERO + 8'd1, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: plain_value = 16'h0000;
            1: plain_value = 16'hFFFF;
            4: plain_value = asef_pkg::PLAIN_RESET;
            default: plain_value = 16'($urandom_range(0, 65535));
         endcase
         set_plain(plain_value);
         if (p == 2) long_hold = 1'b1;
         while (bytes_sent < BYTES_WANTED * (p + 1) / PHASES) begin
            no_gaps = ($urandom_range(0, 6) == 0);
            r = $urandom_range(0, 99);
            if (r < 50) send_sgr();
            else if (r < 60) send_erase();
            else if (r < 82) send_text();
            else send_broken();
         end
      end

      release_req();
      wait (outstanding == 0);
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("PASS ansi_sgr_escape_filter_unit");
      end else begin
         $display("FAIL ansi_sgr_escape_filter_unit");
      end
      $finish;
   end

endmodule
